@@ rtl/b32_pkg.sv @@
// ----------------------------------------------------------------------------
// b32_pkg: shared constants, types and helpers for the base-32 group encoder
// Group geometry, character codes and the job handed from gather to serialiser.
// ----------------------------------------------------------------------------
package b32_pkg;

  localparam int GroupBytes  = 5;
  localparam int DigitBits   = 5;
  localparam int GroupDigits = 8;
  localparam int ByteW       = 8;
  localparam int ValueW      = GroupBytes * ByteW;
  localparam int CharW       = 7;
  localparam int FillW       = 3;
  localparam int CntW        = 4;

  // Character codes
  localparam logic [CharW-1:0] CharZero    = 7'h30;  // '0'
  localparam logic [CharW-1:0] CharAlphaLo = 7'h57;  // 'a' less ten
  localparam logic [CharW-1:0] CharNoPad   = 7'h5F;  // '_'
  localparam logic [CharW-1:0] CharPad1    = 7'h7A;  // 'z'
  localparam logic [CharW-1:0] CharPad2    = 7'h79;  // 'y'
  localparam logic [CharW-1:0] CharPad3    = 7'h78;  // 'x'
  localparam logic [CharW-1:0] CharPad4    = 7'h77;  // 'w'

  localparam logic [DigitBits-1:0] DigitTen = 5'd10;

  // Work for the serialiser: an optional group of eight digits, then an
  // optional trailer character
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic              has_group;
    logic              has_trailer;
    logic [CharW-1:0]  trailer_char;
  } b32_job_t;

  // Map one 5-bit digit to '0'-'9', 'a'-'v'
  function automatic logic [CharW-1:0] digit_char(input logic [DigitBits-1:0] d);
    logic [CharW-1:0] dx;
    dx = {{(CharW-DigitBits){1'b0}}, d};
    return (d < DigitTen) ? CharZero + dx : CharAlphaLo + dx;
  endfunction

  // Trailer for a final group holding fill bytes (zero or five: no padding)
  function automatic logic [CharW-1:0] pad_mark(input logic [FillW-1:0] fill);
    logic [CharW-1:0] c;
    case (fill)
      3'd1:    c = CharPad4;
      3'd2:    c = CharPad3;
      3'd3:    c = CharPad2;
      3'd4:    c = CharPad1;
      default: c = CharNoPad;
    endcase
    return c;
  endfunction

endpackage

@@ rtl/b32_intf.sv @@
// ----------------------------------------------------------------------------
// b32 channel interfaces
// Valid/ready channels for message bytes in and characters out.
// ----------------------------------------------------------------------------
interface b32_byte_if;
  import b32_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_value;
  logic             no_byte;
  logic             message_end;

  modport source (output valid, output byte_value, output no_byte,
                  output message_end, input ready);
  modport sink   (input valid, input byte_value, input no_byte,
                  input message_end, output ready);
endinterface

interface b32_char_if;
  import b32_pkg::*;

  logic             valid;
  logic             ready;
  logic [CharW-1:0] char_code;
  logic             last_of_run;
  logic             is_trailer;

  modport source (output valid, output char_code, output last_of_run,
                  output is_trailer, input ready);
  modport sink   (input valid, input char_code, input last_of_run,
                  input is_trailer, output ready);
endinterface

@@ rtl/base32_group_encoder.sv @@
// ----------------------------------------------------------------------------
// base32_group_encoder: byte stream to base-32 text
// Gathers bytes in groups of five and sends each as eight base-32 digits.
// ----------------------------------------------------------------------------
// Usage:
//   byte_i carries one item per handshake: a byte (unless no_byte) and a
//   message_end flag. char_o carries one ASCII character per handshake, with
//   last_of_run on the final character an item causes and is_trailer on the
//   pad-count trailer ('_', 'z', 'y', 'x', 'w') that closes each message.
//   A full group gives eight digits; message_end flushes a short group padded
//   with zero bytes, then the trailer. An empty message gives '_' alone.
// Path: an accepted item is written into the job register, and the
//   serialiser then loads the job into its own registers and drives the
//   first character of the item onto char_o from them.
// Throughput: one character per cycle from the serialiser while char_o.ready
//   is high: eight characters per five bytes. Bytes that complete no group
//   are taken one per cycle while byte_i.ready is high, as earlier digits
//   go out; the single gather-to-serialiser job register sets how far ahead.
// Reset: clears the partial group and drops any pending characters.
// Stall: while char_o.ready is low the current character holds; once the job
//   register is full and not being taken, byte_i.ready falls.
// ----------------------------------------------------------------------------
module base32_group_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  b32_byte_if.sink    byte_i,
  b32_char_if.source  char_o
);
  import b32_pkg::*;

  b32_job_t job;
  logic     job_valid;
  logic     job_ready;

  b32_gather u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_i      (byte_i),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready)
  );

  b32_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .char_o      (char_o)
  );

  // A job waiting for the serialiser must hold
  a_job_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("job changed while waiting");

  // An item that ends the message always leaves a job behind
  a_end_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_i.valid && byte_i.ready && byte_i.message_end |=> job_valid)
    else $error("message end produced no job");

  // A handed-over job starts output on the next cycle
  a_load_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready |=> char_o.valid)
    else $error("loaded job gave no character");

  // The trailer always closes its run
  a_trl_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    char_o.valid && char_o.is_trailer |-> char_o.last_of_run)
    else $error("trailer not marked last");

endmodule

@@ rtl/b32_gather.sv @@
// ----------------------------------------------------------------------------
// b32_gather: byte gathering stage
// Packs bytes little-endian into a 40-bit group and hands a job register to
// the serialiser when a group fills or the message ends.
// ----------------------------------------------------------------------------
module b32_gather (
  input  logic               clk_i,
  input  logic               rst_ni,
  b32_byte_if.sink           byte_i,
  output b32_pkg::b32_job_t  job_o,
  output logic               job_valid_o,
  input  logic               job_ready_i
);
  import b32_pkg::*;

  logic [ValueW-1:0] value_q;
  logic [FillW-1:0]  fill_q;
  logic [ValueW-1:0] value_a;
  logic [FillW-1:0]  fill_a;
  logic              has_byte;
  logic              full;
  logic              produce;
  logic              accept;
  b32_job_t          job_d;
  b32_job_t          job_q;
  logic              job_valid_q;

  // Take the next item whenever the job slot is free or being drained
  assign byte_i.ready = !job_valid_q || job_ready_i;
  assign accept       = byte_i.valid && byte_i.ready;

  // Insert the byte into its lane and work out what the item causes
  always_comb begin
    has_byte = !byte_i.no_byte;
    value_a  = value_q;
    if (has_byte) begin
      for (int i = 0; i < GroupBytes; i++) begin
        if (fill_q == FillW'(i)) begin
          value_a[i*ByteW +: ByteW] = byte_i.byte_value;
        end
      end
    end
    fill_a  = fill_q + {{(FillW-1){1'b0}}, has_byte};
    full    = (fill_a == FillW'(GroupBytes));
    produce = full || byte_i.message_end;

    job_d.value        = value_a;
    job_d.has_group    = produce && (fill_a != '0);
    job_d.has_trailer  = byte_i.message_end;
    job_d.trailer_char = pad_mark(fill_a);
  end

  // Advance the group state; clear it once a job takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      fill_q  <= '0;
    end else if (accept) begin
      if (produce) begin
        value_q <= '0;
        fill_q  <= '0;
      end else begin
        value_q <= value_a;
        fill_q  <= fill_a;
      end
    end
  end

  // Hold the job until the serialiser takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
    end else if (accept) begin
      job_valid_q <= produce;
    end else if (job_ready_i) begin
      job_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && produce) begin
      job_q <= job_d;
    end
  end

  assign job_o       = job_q;
  assign job_valid_o = job_valid_q;

endmodule

@@ rtl/b32_serial.sv @@
// ----------------------------------------------------------------------------
// b32_serial: character serialiser
// Shifts a 40-bit group out as eight base-32 digits, most significant first,
// then the trailer, one character per cycle while char_o.ready is high.
// ----------------------------------------------------------------------------
module b32_serial (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  b32_pkg::b32_job_t  job_i,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  b32_char_if.source         char_o
);
  import b32_pkg::*;

  logic [ValueW-1:0] val_q;
  logic [CntW-1:0]   cnt_q;
  logic              trl_q;
  logic [CharW-1:0]  trl_char_q;
  logic              busy;
  logic              last;
  logic              out_acc;
  logic              load;

  assign busy    = (cnt_q != '0) || trl_q;
  assign last    = (cnt_q == '0) || ((cnt_q == CntW'(1)) && !trl_q);
  assign out_acc = char_o.valid && char_o.ready;

  // Load a new job when idle or as the last character leaves
  assign job_ready_o = !busy || (out_acc && last);
  assign load        = job_valid_i && job_ready_o;

  // Drive the current character from the held state
  assign char_o.valid       = busy;
  assign char_o.char_code   = (cnt_q != '0) ? digit_char(val_q[ValueW-1 -: DigitBits])
                                            : trl_char_q;
  assign char_o.is_trailer  = (cnt_q == '0);
  assign char_o.last_of_run = last;

  // Control: digits left and trailer pending
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      trl_q <= 1'b0;
    end else if (load) begin
      cnt_q <= job_i.has_group ? CntW'(GroupDigits) : '0;
      trl_q <= job_i.has_trailer;
    end else if (out_acc) begin
      if (cnt_q != '0) begin
        cnt_q <= cnt_q - CntW'(1);
      end else begin
        trl_q <= 1'b0;
      end
    end
  end

  // Payload: shift one digit out per delivered digit
  always_ff @(posedge clk_i) begin
    if (load) begin
      val_q      <= job_i.value;
      trl_char_q <= job_i.trailer_char;
    end else if (out_acc && (cnt_q != '0)) begin
      val_q <= {val_q[ValueW-DigitBits-1:0], {DigitBits{1'b0}}};
    end
  end

endmodule
